>>> rtl/lcg_random_in_range_core_macros.svh
// ---------------------------------------------------------------------------
// LCG random-in-range core: assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef LCG_RANDOM_IN_RANGE_CORE_MACROS_SVH
`define LCG_RANDOM_IN_RANGE_CORE_MACROS_SVH

// general form: explicit clock and reset
`define LRR_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// short form for modules with ports named clock and reset
`define LRR_CHECK_CLK(label, prop, msg) `LRR_CHECK(label, clock, reset, prop, msg)

`endif

>>> rtl/lrr_pkg.sv
// ---------------------------------------------------------------------------
// LCG random-in-range package
// Widths, generator constants and operation codes.
// ---------------------------------------------------------------------------
package lrr_pkg;

   localparam int unsigned WordW = 32;

   localparam logic [WordW-1:0] LcgMul  = 32'd1103515245;
   localparam logic [WordW-1:0] LcgInc  = 32'd12345;
   localparam logic [WordW-1:0] SeedMod = 32'd10000;
   localparam int unsigned HighShift    = 16;

   // restoring divider: one quotient bit per cycle
   localparam int unsigned DivSteps = WordW;
   localparam int unsigned CountW   = $clog2(DivSteps);

   localparam logic [0:0] OpReseed = 1'b0;
   localparam logic [0:0] OpDraw   = 1'b1;

endpackage

>>> rtl/lrr_req_if.sv
// ---------------------------------------------------------------------------
// LCG random-in-range request channel
// Valid/ready channel carrying one operation item.
// ---------------------------------------------------------------------------
interface lrr_req_if;
   logic                          valid;
   logic                          ready;
   logic [0:0]                    operation;
   logic [lrr_pkg::WordW-1:0]     epoch_secs;
   logic [lrr_pkg::WordW-1:0]     range_low;
   logic [lrr_pkg::WordW-1:0]     range_high;

   modport source (output valid, operation, epoch_secs, range_low, range_high,
                   input ready);
   modport sink   (input valid, operation, epoch_secs, range_low, range_high,
                   output ready);
endinterface

>>> rtl/lrr_rsp_if.sv
// ---------------------------------------------------------------------------
// LCG random-in-range response channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface lrr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lrr_pkg::WordW-1:0]     value;
   logic                          span_zero;

   modport source (output valid, value, span_zero, input ready);
   modport sink   (input valid, value, span_zero, output ready);
endinterface

>>> rtl/lcg_random_in_range_core.sv
// ---------------------------------------------------------------------------
// LCG random-in-range core
// 32-bit linear congruential generator with reseed and ranged draw.
// ---------------------------------------------------------------------------
// One item at a time. A reseed loads seed = epoch_secs mod 10000 and returns
// the new seed. A draw advances seed = seed*1103515245 + 12345 (mod 2^32) and
// returns range_low + ((seed >> 16) mod (range_high - range_low)), all mod
// 2^32; an empty span returns range_low with span_zero set, seed still
// advancing. Both modulo operations run on one shared restoring divider that
// produces one quotient bit per cycle; an empty-span draw skips the divider.
// The multiply is a single registered 32x32 step. The result sits in an
// output register, so a new request transfer is taken while the previous
// result still waits on rsp; the block only stalls finishing an item when
// that register is still full.
// ---------------------------------------------------------------------------
module lcg_random_in_range_core (
   input  logic      clock,
   input  logic      reset,
   lrr_req_if.sink   req_chan,
   lrr_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_INC,
      ST_DIV,
      ST_FIN
   } state_type;

   state_type                        state_ff, state_in;
   logic [lrr_pkg::WordW-1:0]        seed_ff, seed_in;
   logic [lrr_pkg::WordW-1:0]        prod_ff, prod_in;
   logic [lrr_pkg::WordW-1:0]        dvd_ff, dvd_in;
   logic [lrr_pkg::WordW-1:0]        rem_ff, rem_in;
   logic [lrr_pkg::WordW-1:0]        divisor_ff, divisor_in;
   logic [lrr_pkg::WordW-1:0]        low_ff, low_in;
   logic [lrr_pkg::CountW-1:0]       count_ff, count_in;
   logic [0:0]                       op_ff, op_in;
   logic                             zero_ff, zero_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lrr_pkg::WordW-1:0]        rsp_value_ff, rsp_value_in;
   logic                             rsp_zero_ff, rsp_zero_in;

   logic                             req_xfer;
   logic                             out_free;
   logic [lrr_pkg::WordW-1:0]        mul_low;
   logic [lrr_pkg::WordW-1:0]        seed_adv;
   logic [lrr_pkg::WordW:0]          rem_shift;
   logic [lrr_pkg::WordW:0]          rem_diff;

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign req_xfer          = req_chan.valid && req_chan.ready;
   assign out_free          = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value     = rsp_value_ff;
   assign rsp_chan.span_zero = rsp_zero_ff;

   // low word of the LCG multiply
   assign mul_low  = seed_ff * lrr_pkg::LcgMul;
   assign seed_adv = prod_ff + lrr_pkg::LcgInc;

   // shared divider step: shift in next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, dvd_ff[lrr_pkg::WordW-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      divisor_in   = divisor_ff;
      low_in       = low_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_zero_in  = rsp_zero_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in    = req_chan.operation;
               low_in   = req_chan.range_low;
               rem_in   = '0;
               count_in = '0;
               zero_in  = 1'b0;
               if (req_chan.operation == lrr_pkg::OpReseed) begin
                  dvd_in     = req_chan.epoch_secs;
                  divisor_in = lrr_pkg::SeedMod;
                  state_in   = ST_DIV;
               end else begin
                  divisor_in = req_chan.range_high - req_chan.range_low;
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = mul_low;
            state_in = ST_INC;
         end
         ST_INC: begin
            seed_in = seed_adv;
            dvd_in  = lrr_pkg::WordW'(seed_adv >> lrr_pkg::HighShift);
            if (divisor_ff == '0) begin
               zero_in  = 1'b1;
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dvd_in   = {dvd_ff[lrr_pkg::WordW-2:0], 1'b0};
            rem_in   = rem_diff[lrr_pkg::WordW] ? rem_shift[lrr_pkg::WordW-1:0]
                                                : rem_diff[lrr_pkg::WordW-1:0];
            count_in = count_ff + 1'b1;
            if (count_ff == lrr_pkg::CountW'(lrr_pkg::DivSteps - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == lrr_pkg::OpReseed) begin
                  seed_in      = rem_ff;
                  rsp_value_in = rem_ff;
                  rsp_zero_in  = 1'b0;
               end else if (zero_ff) begin
                  rsp_value_in = low_ff;
                  rsp_zero_in  = 1'b1;
               end else begin
                  rsp_value_in = low_ff + rem_ff;
                  rsp_zero_in  = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff      <= prod_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      low_ff       <= low_in;
      count_ff     <= count_in;
      op_ff        <= op_in;
      zero_ff      <= zero_in;
      rsp_value_ff <= rsp_value_in;
      rsp_zero_ff  <= rsp_zero_in;
   end

endmodule

>>> rtl/lrr_checker.sv
// ---------------------------------------------------------------------------
// LCG random-in-range port checker
// Watches the core's channels and checks result behavior over time.
// ---------------------------------------------------------------------------
`include "lcg_random_in_range_core_macros.svh"

module lrr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [0:0]                req_operation,
   input logic [lrr_pkg::WordW-1:0] req_range_low,
   input logic [lrr_pkg::WordW-1:0] req_range_high,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [lrr_pkg::WordW-1:0] rsp_value,
   input logic                      rsp_span_zero
);

   logic                      req_xfer;
   logic                      rsp_xfer;
   logic [1:0]                inflight_ff, inflight_in;
   logic [0:0]                last_op_ff;
   logic                      last_empty_ff;
   logic [lrr_pkg::WordW-1:0] last_low_ff;
   logic                      rsp_stall;
   logic [lrr_pkg::WordW:0]   rsp_word;
   logic                      solo_rsp;
   logic                      reseed_rsp;
   logic                      empty_rsp;
   logic                      reseed_ok;
   logic                      empty_ok;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_word   = {rsp_value, rsp_span_zero};
   // only one item outstanding: the shown result belongs to the last request
   assign solo_rsp   = rsp_valid && inflight_ff == 2'd1;
   assign reseed_rsp = solo_rsp && last_op_ff == lrr_pkg::OpReseed;
   assign empty_rsp  = solo_rsp && last_op_ff == lrr_pkg::OpDraw && last_empty_ff;
   assign reseed_ok  = rsp_value < lrr_pkg::SeedMod && !rsp_span_zero;
   assign empty_ok   = rsp_span_zero && rsp_value == last_low_ff;

   always_comb begin
      inflight_in = inflight_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
      if (req_xfer) begin
         last_op_ff    <= req_operation;
         last_empty_ff <= (req_range_high == req_range_low);
         last_low_ff   <= req_range_low;
      end
   end

   // a stalled result holds
   `LRR_CHECK_CLK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "rsp not held")

   // no result without an outstanding request
   `LRR_CHECK_CLK(a_no_extra_rsp, rsp_valid |-> inflight_ff != 2'd0, "result without request")

   // one item at a time: busy right after a transfer
   `LRR_CHECK_CLK(a_busy_after_req, req_xfer |=> !req_ready, "ready right after transfer")

   // reseed result is the reduced seed
   `LRR_CHECK_CLK(a_reseed_range, reseed_rsp |-> reseed_ok, "reseed value out of range")

   // empty span returns the low bound and flags it
   `LRR_CHECK_CLK(a_empty_span, empty_rsp |-> empty_ok, "empty span result wrong")

endmodule

bind lcg_random_in_range_core lrr_checker u_lrr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_operation  (req_chan.operation),
   .req_range_low  (req_chan.range_low),
   .req_range_high (req_chan.range_high),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_value      (rsp_chan.value),
   .rsp_span_zero  (rsp_chan.span_zero)
);
